// ===== rtl/icts_pkg.sv =====
// shared constants, types and helpers for the inverse curve table search
package icts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_BITS  = 16;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS  = ADDR_BITS + 1;

  localparam logic [VALUE_BITS-1:0] FULL_SCALE = {VALUE_BITS{1'b1}};

  // shared divider: for the fraction pass the dividend is a numerator shifted up by VALUE_BITS
  localparam int DIVIDEND_BITS  = 2 * VALUE_BITS;
  localparam int DIVISOR_BITS   = VALUE_BITS;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES     = DIVIDEND_BITS / DIV_RADIX_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_LOW    = 2'd1,
    KIND_HIGH   = 2'd2,
    KIND_PASS   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVISOR_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DIVIDEND_BITS-1:0] quotient;
  } div_rsp_t;

  // clip a wide quotient to full scale
  function automatic logic [VALUE_BITS-1:0] sat_value(input logic [DIVIDEND_BITS-1:0] q);
    logic [VALUE_BITS-1:0] r;
    if (q[DIVIDEND_BITS-1:VALUE_BITS] != '0) begin
      r = FULL_SCALE;
    end else begin
      r = q[VALUE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/inverse_curve_table_search.sv =====
// inverse tone curve lookup: table search over memory, interpolation by shared divider
// a write beat is taken while idle; a query holds the input until done: a short table
// passes the target back, low or high clamps follow the end checks, and interpolation
// follows table probes through the single memory port and two divider passes
// one beat at a time; the output register lets the next beat in while a result waits
// rst is synchronous: clears the fsm, output valid and entry_count; table contents stay
module inverse_curve_table_search import icts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [COUNT_BITS-1:0] cfg_data,
  // input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [ADDR_BITS-1:0]  entry_index,
  input  logic [VALUE_BITS-1:0] entry_value,
  input  logic [VALUE_BITS-1:0] target,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] curve_input,
  output logic [1:0]            result_kind
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_FIRST     = 9'b000000010,
    S_CHK_FIRST = 9'b000000100,
    S_CHK_LAST  = 9'b000001000,
    S_SEARCH    = 9'b000010000,
    S_CMP       = 9'b000100000,
    S_DIV_FRAC  = 9'b001000000,
    S_SCALE     = 9'b010000000,
    S_DIV_OUT   = 9'b100000000
  } state_t;

  localparam logic [VALUE_BITS-1:0] ZERO_VALUE = '0;

  state_t                state;
  logic                  pending;     // result held until output register is free
  logic [COUNT_BITS-1:0] entry_count;

  // query context
  logic [VALUE_BITS-1:0] tgt;
  logic [ADDR_BITS-1:0]  last;        // index of last entry in use
  logic [ADDR_BITS-1:0]  lo;
  logic [ADDR_BITS-1:0]  hi;
  logic [ADDR_BITS-1:0]  mid;
  logic [VALUE_BITS-1:0] lo_val;
  logic [VALUE_BITS-1:0] hi_val;
  logic [VALUE_BITS-1:0] frac;
  logic [VALUE_BITS-1:0] res;
  kind_t                 kind;

  // memory port
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic [ADDR_BITS-1:0]  rd_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic                     div_start;
  logic [DIVIDEND_BITS-1:0] div_dividend;
  logic [DIVISOR_BITS-1:0]  div_divisor;

  logic                  in_take;
  logic                  out_free;
  logic [COUNT_BITS-1:0] count_sat;
  logic [COUNT_BITS-1:0] count_m1;
  logic [ADDR_BITS:0]    span_sum;
  logic [ADDR_BITS-1:0]  probe;
  logic [ADDR_BITS+VALUE_BITS-1:0]              pos;      // lo + frac in fixed point
  logic [ADDR_BITS+2*VALUE_BITS-1:0]            pos_full; // pos times full scale

  // new beats only while idle and no result is waiting to be loaded
  assign in_stall = (state != S_IDLE) || pending;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // count above table depth clamps to the depth
  assign count_sat = (entry_count > COUNT_BITS'(TABLE_DEPTH)) ?
                     COUNT_BITS'(TABLE_DEPTH) : entry_count;
  assign count_m1  = count_sat - 1'b1;

  assign span_sum = {1'b0, lo} + {1'b0, hi};
  assign probe    = span_sum[ADDR_BITS:1];

  // result = floor(full * (lo + frac) / (count - 1)); low bits of the product drop
  // before the divide since the denominator carries the same scale
  assign pos      = {lo, frac};
  assign pos_full = {pos, ZERO_VALUE} - {{VALUE_BITS{1'b0}}, pos};

  // read address for the probe issued this cycle; writes take the port while idle
  always_comb begin
    case (state)
      S_FIRST:     rd_addr = '0;
      S_CHK_FIRST: rd_addr = last;
      S_SEARCH:    rd_addr = probe;
      default:     rd_addr = '0;
    endcase
  end

  assign ram_we   = in_take && (opcode == OP_WRITE);
  assign ram_addr = ram_we ? entry_index : rd_addr;

  icts_ram #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (entry_value),
    .rdata (ram_rdata)
  );

  assign div_req = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

  icts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write) begin
      entry_count <= cfg_data;
    end
  end

  // control fsm and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pending && out_free) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take && (opcode == OP_QUERY)) begin
            if (count_sat < COUNT_BITS'(2)) begin
              pending <= 1'b1;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          state <= S_CHK_FIRST;
        end
        S_CHK_FIRST: begin
          // target at or below the first entry clamps low
          if (tgt <= ram_rdata) begin
            pending <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_CHK_LAST;
          end
        end
        S_CHK_LAST: begin
          // target at or above the last entry clamps high
          if (tgt >= ram_rdata) begin
            pending <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if ((hi - lo) > ADDR_BITS'(1)) begin
            state <= S_CMP;
          end else if (hi_val > lo_val) begin
            div_start <= 1'b1;
            state     <= S_DIV_FRAC;
          end else begin
            // flat or falling bracket: zero fraction
            state <= S_SCALE;
          end
        end
        S_CMP: begin
          state <= S_SEARCH;
        end
        S_DIV_FRAC: begin
          if (div_rsp.done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          div_start <= 1'b1;
          state     <= S_DIV_OUT;
        end
        S_DIV_OUT: begin
          if (div_rsp.done) begin
            pending <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pending && out_free) begin
      curve_input <= res;
      result_kind <= kind;
    end
    case (state)
      S_IDLE: begin
        if (in_take) begin
          tgt  <= target;
          last <= count_m1[ADDR_BITS-1:0];
          res  <= target;
          kind <= KIND_PASS;
          frac <= '0;
        end
      end
      S_CHK_FIRST: begin
        lo_val <= ram_rdata;
        lo     <= '0;
        res    <= '0;
        kind   <= KIND_LOW;
      end
      S_CHK_LAST: begin
        hi_val <= ram_rdata;
        hi     <= last;
        res    <= FULL_SCALE;
        kind   <= KIND_HIGH;
      end
      S_SEARCH: begin
        mid          <= probe;
        div_dividend <= {tgt - lo_val, ZERO_VALUE};
        div_divisor  <= hi_val - lo_val;
      end
      S_CMP: begin
        // probe at or below target moves the low end up
        if (ram_rdata <= tgt) begin
          lo     <= mid;
          lo_val <= ram_rdata;
        end else begin
          hi     <= mid;
          hi_val <= ram_rdata;
        end
      end
      S_DIV_FRAC: begin
        if (div_rsp.done) begin
          frac <= sat_value(div_rsp.quotient);
        end
      end
      S_SCALE: begin
        div_dividend <= DIVIDEND_BITS'(pos_full[ADDR_BITS+2*VALUE_BITS-1:VALUE_BITS]);
        div_divisor  <= DIVISOR_BITS'(last);
      end
      S_DIV_OUT: begin
        if (div_rsp.done) begin
          res  <= sat_value(div_rsp.quotient);
          kind <= KIND_INTERP;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/icts_ram.sv =====
// single-port curve table memory with registered read data
module icts_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/icts_div.sv =====
// iterative restoring divider, two quotient bits per cycle
module icts_div import icts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy;
  logic                     done;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [DIVIDEND_BITS-1:0] quo_next;
  logic [DIVISOR_BITS-1:0]  rem_next;

  always_comb begin
    logic [DIVISOR_BITS:0]   shifted;
    logic [DIVISOR_BITS+1:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      shifted = {rem_next, quo_next[DIVIDEND_BITS-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs};
      if (!trial[DIVISOR_BITS+1]) begin
        rem_next = trial[DIVISOR_BITS-1:0];
        quo_next = {quo_next[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem_next = shifted[DIVISOR_BITS-1:0];
        quo_next = {quo_next[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the inverse curve table search block
module testbench import icts_pkg::*; ();

  // cycles allowed after the last answer for a write still in flight or a slow query
  localparam int LATENCY_WAIT = 80;
  // a legal run ends well before this limit, so reaching it means a hang
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    kind_t                 kind;
  } answer_t;

  typedef enum {CURVE_RISING, CURVE_PLATEAU, CURVE_SCRAMBLED} curve_shape_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [COUNT_BITS-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  opcode      = OP_WRITE;
  logic [ADDR_BITS-1:0]  entry_index = '0;
  logic [VALUE_BITS-1:0] entry_value = '0;
  logic [VALUE_BITS-1:0] target      = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [VALUE_BITS-1:0] curve_input;
  logic [1:0]            result_kind;

  // shadow copy of the block state, updated at the edge where a beat is accepted
  logic [VALUE_BITS-1:0] shadow_curve [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] shadow_count = '0;

  // answers the block owes, oldest first
  answer_t answers_due[$];
  answer_t due;

  int send_idle_pct  = 25;
  int recv_stall_pct = 60;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int beats_sent     = 0;
  int answers_seen   = 0;
  int count_settings = 0;

  inverse_curve_table_search uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .target     (target),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .curve_input(curve_input),
    .result_kind(result_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d answers still owed", cycle_count,
             answers_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // inverse lookup: which curve input gives the goal output
  function automatic answer_t invert_curve(input logic [VALUE_BITS-1:0] goal);
    answer_t a;
    longint unsigned n, lo, hi, mid, lo_val, hi_val, frac, num, den, quo;
    a.value = '0;
    a.kind  = KIND_INTERP;
    // counts past the table depth act as a full table
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    if (n < 2) begin
      a.value = goal;
      a.kind  = KIND_PASS;
    end else if (goal <= shadow_curve[0]) begin
      a.kind = KIND_LOW;
    end else if (goal >= shadow_curve[n-1]) begin
      a.value = FULL_SCALE;
      a.kind  = KIND_HIGH;
    end else begin
      // bracket search, also run to the end on a table that is not monotone
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (shadow_curve[mid] <= goal) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      lo_val = shadow_curve[lo];
      hi_val = shadow_curve[hi];
      // position inside the bracket as a 0.16 fraction, zero for a flat or falling bracket
      frac = 0;
      if (hi_val > lo_val && goal >= lo_val) begin
        frac = ((goal - lo_val) << VALUE_BITS) / (hi_val - lo_val);
        if (frac > FULL_SCALE) frac = FULL_SCALE;
      end
      num = FULL_SCALE * ((lo << VALUE_BITS) + frac);
      den = (n - 1) << VALUE_BITS;
      quo = num / den;
      a.value = (quo > FULL_SCALE) ? FULL_SCALE : quo[VALUE_BITS-1:0];
    end
    return a;
  endfunction

  // receiver: random stall, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: every accepted beat must match the oldest owed answer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with nothing owed: curve_input %h kind %0d", curve_input,
                   result_kind);
        end
      end else begin
        due = answers_due.pop_front();
        answers_seen++;
        if (curve_input !== due.value || result_kind !== due.kind) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("answer %0d: expected %h %s, got %h kind %0d", answers_seen,
                     due.value, due.kind.name(), curve_input, result_kind);
          end
        end
      end
    end
  end

  // offer one beat, with a random gap in front of it, and hold it until taken
  task automatic send_beat(input logic op, input logic [ADDR_BITS-1:0] idx,
                           input logic [VALUE_BITS-1:0] val,
                           input logic [VALUE_BITS-1:0] goal);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    entry_value <= val;
    target      <= goal;
    do @(posedge clk); while (in_stall);
    // accepted at this edge: the shadow state moves in beat order
    beats_sent++;
    if (op == OP_WRITE) begin
      shadow_curve[idx] = val;
    end else begin
      answers_due.push_back(invert_curve(goal));
    end
  endtask

  // unused fields carry noise so the block must ignore them
  task automatic write_entry(input logic [ADDR_BITS-1:0] idx,
                             input logic [VALUE_BITS-1:0] val);
    send_beat(OP_WRITE, idx, val, VALUE_BITS'($urandom));
  endtask

  task automatic ask(input logic [VALUE_BITS-1:0] goal);
    send_beat(OP_QUERY, ADDR_BITS'($urandom), VALUE_BITS'($urandom), goal);
  endtask

  // stop offering, wait for every owed answer, then let the pipe empty
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // register write only with the block idle
  task automatic set_count(input logic [COUNT_BITS-1:0] n);
    settle(LATENCY_WAIT);
    cfg_write <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    cfg_write    <= 1'b0;
    shadow_count = n;
    count_settings++;
  endtask

  // fill entries 0..n-1 in shuffled order
  task automatic load_curve(input int n, input curve_shape_t shape);
    logic [VALUE_BITS-1:0] vals[$];
    int                    slots[$];
    vals  = {};
    slots = {};
    for (int i = 0; i < n; i++) begin
      if (shape == CURVE_PLATEAU) begin
        // few distinct levels: long flat runs
        vals.push_back(VALUE_BITS'($urandom_range(4) * 32'h3fff));
      end else begin
        vals.push_back(VALUE_BITS'($urandom));
      end
      slots.push_back(i);
    end
    if (shape != CURVE_SCRAMBLED) vals.sort();
    slots.shuffle();
    foreach (slots[k]) write_entry(ADDR_BITS'(slots[k]), vals[slots[k]]);
  endtask

  // goals mostly inside the curve range, some on entries, some at the rails
  function automatic logic [VALUE_BITS-1:0] pick_goal();
    int unsigned           n, r;
    logic [VALUE_BITS-1:0] first, last;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    if (n < 2) return VALUE_BITS'($urandom);
    first = shadow_curve[0];
    last  = shadow_curve[n-1];
    r = $urandom_range(99);
    if (r < 10) return ($urandom_range(1) ? FULL_SCALE : '0);
    if (r < 30) return shadow_curve[$urandom_range(n - 1)];
    if (r < 40 || first >= last) return VALUE_BITS'($urandom);
    return VALUE_BITS'($urandom_range(last, first));
  endfunction

  // count below two: target comes straight back, table ignored
  task automatic test_short_table();
    ask('0);
    ask(FULL_SCALE);
    ask(16'h5a5a);
    // writes give no answer, and they set up the next test
    write_entry(10'd0, 16'h1000);
    write_entry(10'd1, 16'hf000);
    set_count(11'd1);
    ask(16'h1234);
  endtask

  // two entries: clamp at or beyond either end, interpolate between
  task automatic test_two_entries();
    set_count(11'd2);
    ask('0);
    ask(16'h1000);
    ask(16'h1001);
    ask(16'h8000);
    ask(16'hefff);
    ask(16'hf000);
    ask(FULL_SCALE);
  endtask

  // a table that is not monotone still ends its bracket search
  task automatic test_scrambled_table();
    write_entry(10'd0, 16'h0000);
    write_entry(10'd2, 16'h2000);
    write_entry(10'd3, FULL_SCALE);
    set_count(11'd4);
    ask('0);
    ask(16'h8000);
    ask(16'hfffe);
    ask(FULL_SCALE);
  endtask

  // whole table rising, then full depth and counts past it
  task automatic test_full_table();
    int slots[$];
    slots = {};
    for (int i = 0; i < TABLE_DEPTH; i++) slots.push_back(i);
    slots.shuffle();
    // step of 64 per entry with jitter keeps it rising and ends near full scale
    foreach (slots[k]) begin
      write_entry(ADDR_BITS'(slots[k]), VALUE_BITS'(slots[k] * 64 + $urandom_range(63)));
    end
    set_count(11'(TABLE_DEPTH));
    repeat (40) ask(pick_goal());
    set_count(11'h7ff);
    repeat (20) ask(pick_goal());
    set_count(11'(TABLE_DEPTH + 1));
    repeat (10) ask(pick_goal());
  endtask

  // phases of new count, new curve for counts 2 to 200, then queries with a few stray writes
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int phases);
    int r, n, asks;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (phases) begin
      r = $urandom_range(99);
      if (r < 8) begin
        n = $urandom_range(1);
      end else if (r < 80) begin
        n = $urandom_range(24, 2);
      end else if (r < 92) begin
        n = $urandom_range(200, 25);
      end else begin
        n = $urandom_range(2047, 201);
      end
      set_count(11'(n));
      // large counts reuse the table left in place
      if (n >= 2 && n <= 200) begin
        r = $urandom_range(9);
        if (r < 6) begin
          load_curve(n, CURVE_RISING);
        end else if (r < 8) begin
          load_curve(n, CURVE_PLATEAU);
        end else begin
          load_curve(n, CURVE_SCRAMBLED);
        end
      end
      asks = $urandom_range(30, 15);
      repeat (asks) begin
        if ($urandom_range(9) == 0) write_entry(ADDR_BITS'($urandom), VALUE_BITS'($urandom));
        ask(pick_goal());
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_count(11'd16);
    load_curve(16, CURVE_RISING);
    hold_left = LONG_HOLD;
    repeat (40) ask(pick_goal());
    // sender waits for every answer before going on
    settle(0);
    repeat (20) ask(pick_goal());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_short_table();
    test_two_entries();
    test_scrambled_table();
    test_full_table();
    test_random_traffic(25, 60, 3);
    test_random_traffic(60, 25, 3);
    test_random_traffic(0, 0, 3);
    test_output_backpressure();

    settle(LATENCY_WAIT);
    $display("covered %0d beats, %0d answers checked, %0d entry_count settings up to 2047",
             beats_sent, answers_seen, count_settings);
    $display("idle mixes 25/60, 60/25 and none, plus a %0d-cycle receiver hold", LONG_HOLD);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d answers never came", mismatches, answers_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/icts_pkg.sv
rtl/icts_ram.sv
rtl/icts_div.sv
rtl/inverse_curve_table_search.sv
test/testbench.sv
